### hw/rtl/pvd_pkg.sv
// Shared types and constants for the PID valve drive block.
// Used by the register file, the controller and the datapath; depends on nothing.
package pvd_pkg;

	localparam int unsigned CFG_AW = 5;
	localparam int unsigned CFG_DW = 32;

	typedef enum logic [2:0] {
		REG_KP_GAIN       = 3'd0,
		REG_KI_HUNDREDTHS = 3'd1,
		REG_KD_HUNDREDS   = 3'd2,
		REG_CUT_DEADBAND  = 3'd3,
		REG_RETRACT_START = 3'd4,
		REG_EXTEND_START  = 3'd5,
		REG_RETRACT_LIMIT = 3'd6,
		REG_EXTEND_LIMIT  = 3'd7
	} reg_idx_t;

	localparam logic [1:0] DIR_RAISE = 2'd0;
	localparam logic [1:0] DIR_LOWER = 2'd1;
	localparam logic [1:0] DIR_HOLD  = 2'd2;
	localparam logic [1:0] DIR_IDLE  = 2'd3;

	localparam logic [11:0] FLOAT_CODE = 12'd2048;

	localparam logic signed [20:0] INTEG_MAX = 21'sd524287;
	localparam logic signed [20:0] INTEG_MIN = -21'sd524288;
	localparam logic signed [26:0] TOTAL_MAX = 27'sd230000;
	localparam logic signed [26:0] TOTAL_MIN = -27'sd230000;

	// Reciprocals 2^18/100 and 2^24/2300, rounded down.
	localparam logic signed [13:0] RECIP_100  = 14'sd2621;
	localparam logic signed [13:0] RECIP_2300 = 14'sd7294;
	localparam logic [18:0] DIV_100  = 19'd100;
	localparam logic [24:0] DIV_2300 = 25'd2300;

	typedef struct packed {
		logic [7:0]  kp_gain;
		logic [7:0]  ki_hundredths;
		logic [7:0]  kd_hundreds;
		logic [7:0]  cut_deadband;
		logic [11:0] retract_start;
		logic [11:0] extend_start;
		logic [11:0] retract_limit;
		logic [11:0] extend_limit;
	} cfg_t;

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_MUL_P   = 11'b000_0000_0010,
		ST_MUL_D   = 11'b000_0000_0100,
		ST_MUL_I   = 11'b000_0000_1000,
		ST_SUM     = 11'b000_0001_0000,
		ST_Q100    = 11'b000_0010_0000,
		ST_FIX100  = 11'b000_0100_0000,
		ST_MAP     = 11'b000_1000_0000,
		ST_Q2300   = 11'b001_0000_0000,
		ST_FIX2300 = 11'b010_0000_0000,
		ST_DONE    = 11'b100_0000_0000
	} state_t;

	typedef struct packed {
		logic accept;
		logic do_p;
		logic do_d;
		logic do_i;
		logic do_sum;
		logic do_q100;
		logic do_fix100;
		logic do_map;
		logic do_q2300;
		logic do_fix2300;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic skip;
	} status_t;

endpackage

### hw/rtl/pid_valve_drive_core.sv
// PID valve drive with integral deadband. An engaged word runs the multiply, sum, divide
// and map steps on one shared 25x14 multiplier; a floating word (auto off or not cutting)
// goes straight to done. New words are taken only in idle, after the last has run its
// steps; the next word is taken while the last result waits to be taken.
// Reset: config, state and out_valid are reset; error history and integral clear to 0.
module pid_valve_drive_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 delta_dir,
	input  logic [7:0]                 cut_delta,
	input  logic                       auto_engaged,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [11:0]                dac_code,
	output logic                       driving,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pvd_pkg::CFG_AW-1:0] paddr,
	input  logic [pvd_pkg::CFG_DW-1:0] pwdata,
	output logic [pvd_pkg::CFG_DW-1:0] prdata,
	output logic                       pready
);
	import pvd_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	pvd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pvd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	pvd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.status       (status),
		.delta_dir    (delta_dir),
		.cut_delta    (cut_delta),
		.auto_engaged (auto_engaged),
		.dac_code     (dac_code),
		.driving      (driving)
	);

endmodule

### hw/rtl/pvd_regs.sv
// Configuration register file behind the APB-style port.
// Depends on pvd_pkg for the register indexes and the cfg_t bundle.
module pvd_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [pvd_pkg::CFG_AW-1:0] paddr,
	input  logic [pvd_pkg::CFG_DW-1:0] pwdata,
	output logic [pvd_pkg::CFG_DW-1:0] prdata,
	output logic                      pready,
	output pvd_pkg::cfg_t             cfg
);
	import pvd_pkg::*;

	reg_idx_t reg_idx;
	logic     wr_en;
	cfg_t     cfg_q;

	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain       <= 8'd38;
			cfg_q.ki_hundredths <= 8'd2;
			cfg_q.kd_hundreds   <= 8'd28;
			cfg_q.cut_deadband  <= 8'd2;
			cfg_q.retract_start <= 12'd1845;
			cfg_q.extend_start  <= 12'd2250;
			cfg_q.retract_limit <= 12'd450;
			cfg_q.extend_limit  <= 12'd3645;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_KP_GAIN:       cfg_q.kp_gain       <= pwdata[7:0];
				REG_KI_HUNDREDTHS: cfg_q.ki_hundredths <= pwdata[7:0];
				REG_KD_HUNDREDS:   cfg_q.kd_hundreds   <= pwdata[7:0];
				REG_CUT_DEADBAND:  cfg_q.cut_deadband  <= pwdata[7:0];
				REG_RETRACT_START: cfg_q.retract_start <= pwdata[11:0];
				REG_EXTEND_START:  cfg_q.extend_start  <= pwdata[11:0];
				REG_RETRACT_LIMIT: cfg_q.retract_limit <= pwdata[11:0];
				REG_EXTEND_LIMIT:  cfg_q.extend_limit  <= pwdata[11:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_KP_GAIN:       prdata = {24'd0, cfg_q.kp_gain};
			REG_KI_HUNDREDTHS: prdata = {24'd0, cfg_q.ki_hundredths};
			REG_KD_HUNDREDS:   prdata = {24'd0, cfg_q.kd_hundreds};
			REG_CUT_DEADBAND:  prdata = {24'd0, cfg_q.cut_deadband};
			REG_RETRACT_START: prdata = {20'd0, cfg_q.retract_start};
			REG_EXTEND_START:  prdata = {20'd0, cfg_q.extend_start};
			REG_RETRACT_LIMIT: prdata = {20'd0, cfg_q.retract_limit};
			REG_EXTEND_LIMIT:  prdata = {20'd0, cfg_q.extend_limit};
		endcase
	end

endmodule

### hw/rtl/pvd_ctrl.sv
// Sequencer for the valve drive: steps the shared multiplier through one word.
// Depends on pvd_pkg for the state, command and status types.
module pvd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  pvd_pkg::status_t   status,
	output pvd_pkg::cmd_t      cmd
);
	import pvd_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd            = '0;
		cmd.accept     = in_valid && (state_q == ST_IDLE);
		cmd.do_p       = (state_q == ST_MUL_P);
		cmd.do_d       = (state_q == ST_MUL_D);
		cmd.do_i       = (state_q == ST_MUL_I);
		cmd.do_sum     = (state_q == ST_SUM);
		cmd.do_q100    = (state_q == ST_Q100);
		cmd.do_fix100  = (state_q == ST_FIX100);
		cmd.do_map     = (state_q == ST_MAP);
		cmd.do_q2300   = (state_q == ST_Q2300);
		cmd.do_fix2300 = (state_q == ST_FIX2300);
		cmd.load_out   = (state_q == ST_DONE) && out_free;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = status.skip ? ST_DONE : ST_MUL_P;
				end
			end
			ST_MUL_P:   state_nxt = ST_MUL_D;
			ST_MUL_D:   state_nxt = ST_MUL_I;
			ST_MUL_I:   state_nxt = ST_SUM;
			ST_SUM:     state_nxt = ST_Q100;
			ST_Q100:    state_nxt = ST_FIX100;
			ST_FIX100:  state_nxt = ST_MAP;
			ST_MAP:     state_nxt = ST_Q2300;
			ST_Q2300:   state_nxt = ST_FIX2300;
			ST_FIX2300: state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:    state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/pvd_datapath.sv
// Datapath of the valve drive: shared multiplier, PID sums, divides and clamps.
// Depends on pvd_pkg; driven step by step by the commands of pvd_ctrl.
module pvd_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  pvd_pkg::cfg_t    cfg,
	input  pvd_pkg::cmd_t    cmd,
	output pvd_pkg::status_t status,
	input  logic [1:0]       delta_dir,
	input  logic [7:0]       cut_delta,
	input  logic             auto_engaged,
	output logic [11:0]      dac_code,
	output logic             driving
);
	import pvd_pkg::*;

	logic [1:0]         dir_q;
	logic [7:0]         depth_q;
	logic               skip_q;
	logic signed [8:0]  err_q;
	logic signed [8:0]  prev_err_q;
	logic signed [19:0] integ_sum_q;
	logic signed [19:0] integ_q;
	logic signed [19:0] pd_q;
	logic [17:0]        tmag_q;
	logic               tneg_q;
	logic [11:0]        q100_q;
	logic signed [12:0] t_q;
	logic [23:0]        ymag_q;
	logic               yneg_q;
	logic [11:0]        q23_q;
	logic signed [13:0] code_q;
	logic [11:0]        dac_q;
	logic               driving_q;

	logic signed [8:0]  depth_s;
	logic signed [8:0]  err_in;
	logic signed [9:0]  diff;
	logic signed [24:0] mul_a;
	logic signed [13:0] mul_b;
	logic signed [38:0] mul_prod;
	logic signed [9:0]  err_w;
	logic signed [9:0]  band_w;
	logic               in_band;
	logic signed [20:0] isum;
	logic signed [19:0] isat;
	logic signed [26:0] pd_w;
	logic signed [26:0] total;
	logic signed [26:0] total_c;
	logic [17:0]        q100_x;
	logic [18:0]        rem100;
	logic [11:0]        q100_adj;
	logic [12:0]        t_mag;
	logic signed [12:0] range_s;
	logic               yneg;
	logic [23:0]        q23_x;
	logic [24:0]        rem23;
	logic [11:0]        q23_adj;
	logic signed [13:0] start_w;
	logic signed [13:0] mag_w;
	logic signed [13:0] code_nxt;
	logic signed [13:0] ext_lim;
	logic signed [13:0] ret_lim;
	logic signed [13:0] code_c1;
	logic signed [13:0] code_c2;

	assign status.skip = !auto_engaged || (delta_dir == DIR_IDLE);
	assign dac_code    = dac_q;
	assign driving     = driving_q;

	assign depth_s = {1'b0, cut_delta};
	assign err_in  = (delta_dir == DIR_RAISE) ? depth_s : -depth_s;
	assign diff    = {err_q[8], err_q} - {prev_err_q[8], prev_err_q};

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		range_s = '0;
		if (dir_q == DIR_LOWER) begin
			range_s = {1'b0, cfg.retract_limit} - {1'b0, cfg.retract_start};
		end else begin
			range_s = {1'b0, cfg.extend_limit} - {1'b0, cfg.extend_start};
		end
		priority if (cmd.do_p) begin
			mul_a = 25'(err_q);
			mul_b = {6'd0, cfg.kp_gain};
		end else if (cmd.do_d) begin
			mul_a = 25'(diff);
			mul_b = {6'd0, cfg.kd_hundreds};
		end else if (cmd.do_i) begin
			mul_a = 25'(err_q);
			mul_b = {6'd0, cfg.ki_hundredths};
		end else if (cmd.do_q100) begin
			mul_a = {7'd0, tmag_q};
			mul_b = RECIP_100;
		end else if (cmd.do_map) begin
			mul_a = 25'(t_q);
			mul_b = 14'(range_s);
		end else if (cmd.do_q2300) begin
			mul_a = {1'b0, ymag_q};
			mul_b = RECIP_2300;
		end else begin
			mul_a = '0;
			mul_b = '0;
		end
	end

	assign mul_prod = mul_a * mul_b;

	// Integral step: accumulate inside the deadband, saturate, else clear.
	assign err_w   = {err_q[8], err_q};
	assign band_w  = {2'b00, cfg.cut_deadband};
	assign in_band = (err_w > -band_w) && (err_w < band_w);
	assign isum    = {integ_sum_q[19], integ_sum_q} + {{3{mul_prod[17]}}, mul_prod[17:0]};

	always_comb begin
		if (isum > INTEG_MAX) begin
			isat = INTEG_MAX[19:0];
		end else if (isum < INTEG_MIN) begin
			isat = INTEG_MIN[19:0];
		end else begin
			isat = isum[19:0];
		end
	end

	// Total in hundredths, then clamped.
	assign pd_w  = 27'(pd_q);
	assign total = (pd_w <<< 6) + (pd_w <<< 5) + (pd_w <<< 2) + 27'(integ_q);

	always_comb begin
		if (total > TOTAL_MAX) begin
			total_c = TOTAL_MAX;
		end else if (total < TOTAL_MIN) begin
			total_c = TOTAL_MIN;
		end else begin
			total_c = total;
		end
	end

	// The reciprocal estimate is at most one low; one compare corrects it.
	assign q100_x   = 18'(q100_q) * 18'd100;
	assign rem100   = {1'b0, tmag_q} - {1'b0, q100_x};
	assign q100_adj = (rem100 >= DIV_100) ? (q100_q + 12'd1) : q100_q;
	assign t_mag    = {1'b0, q100_adj};

	assign yneg = mul_prod[38];

	assign q23_x   = 24'(q23_q) * 24'd2300;
	assign rem23   = {1'b0, ymag_q} - {1'b0, q23_x};
	assign q23_adj = (rem23 >= DIV_2300) ? (q23_q + 12'd1) : q23_q;
	assign mag_w   = {2'b00, q23_adj};
	assign start_w = (dir_q == DIR_LOWER) ? {2'b00, cfg.retract_start} : {2'b00, cfg.extend_start};

	always_comb begin
		if (dir_q == DIR_HOLD) begin
			code_nxt = {2'b00, FLOAT_CODE};
		end else if (yneg_q) begin
			code_nxt = start_w - mag_w;
		end else begin
			code_nxt = start_w + mag_w;
		end
	end

	// Cap at the extend limit first, then raise to the retract limit.
	assign ext_lim = {2'b00, cfg.extend_limit};
	assign ret_lim = {2'b00, cfg.retract_limit};
	assign code_c1 = (code_q >= ext_lim) ? ext_lim : code_q;
	assign code_c2 = (code_c1 <= ret_lim) ? ret_lim : code_c1;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dir_q   <= delta_dir;
			depth_q <= cut_delta;
			skip_q  <= status.skip;
			err_q   <= err_in;
		end
		if (cmd.do_p) begin
			pd_q <= mul_prod[19:0];
		end
		if (cmd.do_d) begin
			pd_q <= pd_q + {mul_prod[18:0], 1'b0};
		end
		if (cmd.do_i) begin
			integ_q <= in_band ? isat : 20'sd0;
		end
		if (cmd.do_sum) begin
			tneg_q <= total_c[26];
			tmag_q <= total_c[26] ? 18'(-total_c) : total_c[17:0];
		end
		if (cmd.do_q100) begin
			q100_q <= mul_prod[29:18];
		end
		if (cmd.do_fix100) begin
			t_q <= tneg_q ? -t_mag : t_mag;
		end
		if (cmd.do_map) begin
			yneg_q <= yneg ^ (dir_q == DIR_LOWER);
			ymag_q <= yneg ? (24'd0 - mul_prod[23:0]) : mul_prod[23:0];
		end
		if (cmd.do_q2300) begin
			q23_q <= mul_prod[35:24];
		end
		if (cmd.do_fix2300) begin
			code_q <= code_nxt;
		end
		if (cmd.load_out) begin
			if (skip_q || (depth_q <= cfg.cut_deadband)) begin
				dac_q     <= FLOAT_CODE;
				driving_q <= 1'b0;
			end else begin
				dac_q     <= code_c2[11:0];
				driving_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q  <= '0;
			integ_sum_q <= '0;
		end else if (cmd.load_out && !skip_q) begin
			prev_err_q  <= err_q;
			integ_sum_q <= integ_q;
		end
	end

endmodule

### hw/rtl/pvd_checker.sv
// Port-level assertions for the valve drive, bound to pid_valve_drive_core.
// Depends on pvd_pkg for the float code.
module pvd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [11:0] dac_code,
	input logic        driving
);
	import pvd_pkg::*;

	// A word keeps the block busy in the cycle after it is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
	else $error("block took two words in consecutive cycles");

	// Going idle again means the result was just loaded.
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
	else $error("block went idle without presenting a result");

	// A result that does not drive the valve is always the float code.
	a_float_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !driving |-> dac_code == FLOAT_CODE)
	else $error("non-driving result is not the float code");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dac_code) && $stable(driving))
	else $error("stalled result changed or was dropped");

endmodule

bind pid_valve_drive_core pvd_checker u_pvd_checker (.*);

### sim/pvd_drive_checker.sv
// Checker for the PID valve drive core: keeps its own copy of the registers and of the
// controller state, predicts each result word and compares it with what the block sends.
// Depends on pvd_pkg for the register, direction and float code definitions.
`timescale 1ns / 100ps

module pvd_drive_checker
	import pvd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [1:0]          delta_dir,
	input  logic [7:0]          cut_delta,
	input  logic                auto_engaged,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [11:0]         dac_code,
	input  logic                driving,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [CFG_DW-1:0]   pwdata,
	output int                  words_pending,
	output int                  mismatch_count,
	output int                  results_seen
);

	localparam longint ACC_CEIL    = 524287;
	localparam longint ACC_FLOOR   = -524288;
	localparam longint EFFORT_SPAN = 2300;
	localparam longint CENTS       = 100;
	localparam longint TICK_MS     = 50;

	typedef struct packed {
		logic [11:0] code;
		logic        driving;
	} drive_word_t;

	cfg_t               regs;
	logic signed [8:0]  last_err;
	logic signed [19:0] integ_acc;
	drive_word_t        drive_q[$];
	int                 fail_tally = 0;
	int                 seen_tally = 0;

	assign mismatch_count = fail_tally;
	assign results_seen   = seen_tally;

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		fail_tally++;
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic drive_word_t advance_controller(input logic [1:0] dir,
			input logic [7:0] depth, input logic engaged);
		drive_word_t res;
		longint band, err, p_part, d_part, integ, total, effort, code;
		res.code    = FLOAT_CODE;
		res.driving = 1'b0;
		if (!engaged || dir == DIR_IDLE) begin
			return res;
		end
		band   = longint'(regs.cut_deadband);
		err    = (dir == DIR_RAISE) ? longint'(depth) : -longint'(depth);
		p_part = longint'(regs.kp_gain) * err;
		d_part = longint'(regs.kd_hundreds) * CENTS * (err - longint'(last_err)) / TICK_MS;
		if (-band < err && err < band) begin
			integ = longint'(integ_acc) + longint'(regs.ki_hundredths) * err;
			if (integ > ACC_CEIL) integ = ACC_CEIL;
			if (integ < ACC_FLOOR) integ = ACC_FLOOR;
		end else begin
			integ = 0;
		end
		total = CENTS * p_part + integ + CENTS * d_part;
		if (total > EFFORT_SPAN * CENTS) total = EFFORT_SPAN * CENTS;
		if (total < -EFFORT_SPAN * CENTS) total = -EFFORT_SPAN * CENTS;
		effort = total / CENTS;
		code = longint'(FLOAT_CODE);
		if (dir == DIR_LOWER) begin
			code = effort * (longint'(regs.retract_limit) - longint'(regs.retract_start))
				/ (-EFFORT_SPAN) + longint'(regs.retract_start);
		end else if (dir == DIR_RAISE) begin
			code = effort * (longint'(regs.extend_limit) - longint'(regs.extend_start))
				/ EFFORT_SPAN + longint'(regs.extend_start);
		end
		if (code >= longint'(regs.extend_limit)) code = longint'(regs.extend_limit);
		if (code <= longint'(regs.retract_limit)) code = longint'(regs.retract_limit);
		if (longint'(depth) > band) begin
			res.code    = code[11:0];
			res.driving = 1'b1;
		end
		integ_acc = integ[19:0];
		last_err  = err[8:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_word_t want;
		if (!arst_n) begin
			regs.kp_gain       = 8'd38;
			regs.ki_hundredths = 8'd2;
			regs.kd_hundreds   = 8'd28;
			regs.cut_deadband  = 8'd2;
			regs.retract_start = 12'd1845;
			regs.extend_start  = 12'd2250;
			regs.retract_limit = 12'd450;
			regs.extend_limit  = 12'd3645;
			last_err  = '0;
			integ_acc = '0;
			drive_q.delete();
			words_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[CFG_AW-1:2]))
					REG_KP_GAIN:       regs.kp_gain       = pwdata[7:0];
					REG_KI_HUNDREDTHS: regs.ki_hundredths = pwdata[7:0];
					REG_KD_HUNDREDS:   regs.kd_hundreds   = pwdata[7:0];
					REG_CUT_DEADBAND:  regs.cut_deadband  = pwdata[7:0];
					REG_RETRACT_START: regs.retract_start = pwdata[11:0];
					REG_EXTEND_START:  regs.extend_start  = pwdata[11:0];
					REG_RETRACT_LIMIT: regs.retract_limit = pwdata[11:0];
					REG_EXTEND_LIMIT:  regs.extend_limit  = pwdata[11:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				seen_tally++;
				if (drive_q.size() == 0) begin
					report_mismatch("unexpected result word, dac_code", 32'(dac_code), 0);
				end else begin
					want = drive_q.pop_front();
					if (dac_code !== want.code) begin
						report_mismatch("dac_code", 32'(dac_code), 32'(want.code));
					end
					if (driving !== want.driving) begin
						report_mismatch("driving", 32'(driving), 32'(want.driving));
					end
				end
			end
			if (in_valid && !in_stall) begin
				drive_q.push_back(advance_controller(delta_dir, cut_delta, auto_engaged));
			end
			words_pending <= drive_q.size();
		end
	end

endmodule

### sim/tb_pid_valve_drive_core.sv
// Top of the PID valve drive testbench: clock, reset, control word stimulus, register
// programming over the APB port and the final verdict. Depends on pvd_pkg, the core and
// pvd_drive_checker, which predicts and compares every result word.
`timescale 1ns / 100ps

module tb_pid_valve_drive_core;
	import pvd_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASE_COUNT  = 10;
	localparam int PHASE_WORDS  = 42;
	localparam int DRAIN_CYCLES = 20;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic [1:0]        delta_dir    = DIR_IDLE;
	logic [7:0]        cut_delta    = '0;
	logic              auto_engaged = 1'b0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [11:0]       dac_code;
	logic              driving;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [CFG_AW-1:0] paddr        = '0;
	logic [CFG_DW-1:0] pwdata       = '0;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	int words_pending;
	int mismatch_count;
	int results_seen;

	int unsigned snd_idle_pct  = 22;
	int unsigned rcv_stall_pct = 79;
	int unsigned cycle_cnt     = 0;
	int unsigned words_sent    = 0;
	int unsigned engaged_sent  = 0;
	int unsigned settings_used = 0;
	int          cur_band      = 2;

	pid_valve_drive_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.delta_dir    (delta_dir),
		.cut_delta    (cut_delta),
		.auto_engaged (auto_engaged),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.dac_code     (dac_code),
		.driving      (driving),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	pvd_drive_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.delta_dir      (delta_dir),
		.cut_delta      (cut_delta),
		.auto_engaged   (auto_engaged),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.dac_code       (dac_code),
		.driving        (driving),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.words_pending  (words_pending),
		.mismatch_count (mismatch_count),
		.results_seen   (results_seen)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d words outstanding.",
				cycle_cnt, words_pending);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_word(input logic [1:0] dir, input logic [7:0] depth,
			input logic engaged);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		delta_dir    <= dir;
		cut_delta    <= depth;
		auto_engaged <= engaged;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
		if (engaged && dir != DIR_IDLE) engaged_sent++;
	endtask

	task automatic await_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (words_pending != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	task automatic program_settings(input int kind);
		int unsigned kp, ki, kd, band, rs, es, rl, el;
		case (kind)
			0: begin
				kp = 38; ki = 2; kd = 28; band = 2;
				rs = 1845; es = 2250; rl = 450; el = 3645;
			end
			1: begin
				kp = 0; ki = 0; kd = 0; band = 0;
				rs = 0; es = 0; rl = 0; el = 0;
			end
			2: begin
				kp = 255; ki = 255; kd = 255; band = 255;
				rs = 4095; es = 4095; rl = 4095; el = 4095;
			end
			4: begin
				kp = $urandom_range(0, 255); ki = $urandom_range(0, 255);
				kd = $urandom_range(0, 255); band = $urandom_range(0, 40);
				rs = $urandom_range(0, 4095); es = $urandom_range(0, 4095);
				rl = $urandom_range(2500, 4095); el = $urandom_range(0, 1500);
			end
			5: begin
				kp = $urandom_range(0, 3); ki = $urandom_range(200, 255);
				kd = $urandom_range(0, 3); band = $urandom_range(100, 255);
				rs = $urandom_range(1500, 2047); es = $urandom_range(2048, 2600);
				rl = $urandom_range(0, rs); el = $urandom_range(es, 4095);
			end
			6: begin
				kp = $urandom_range(0, 255); ki = $urandom_range(0, 255);
				kd = $urandom_range(0, 255); band = $urandom_range(0, 255);
				rs = $urandom_range(0, 4095); es = $urandom_range(0, 4095);
				rl = $urandom_range(0, 4095); el = $urandom_range(0, 4095);
			end
			default: begin
				kp = $urandom_range(0, 80); ki = $urandom_range(0, 30);
				kd = $urandom_range(0, 60); band = $urandom_range(0, 12);
				rs = $urandom_range(1500, 2047); es = $urandom_range(2048, 2600);
				rl = $urandom_range(0, rs); el = $urandom_range(es, 4095);
			end
		endcase
		write_reg(REG_KP_GAIN, kp);
		write_reg(REG_KI_HUNDREDTHS, ki);
		write_reg(REG_KD_HUNDREDS, kd);
		write_reg(REG_CUT_DEADBAND, band);
		write_reg(REG_RETRACT_START, rs);
		write_reg(REG_EXTEND_START, es);
		write_reg(REG_RETRACT_LIMIT, rl);
		write_reg(REG_EXTEND_LIMIT, el);
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		cur_band = band;
		settings_used++;
	endtask

	task automatic run_phase(input int unsigned n_engaged);
		int unsigned done_cnt;
		int          base, depth, len;
		logic [1:0]  dir;
		done_cnt = 0;
		while (done_cnt < n_engaged) begin
			if ($urandom_range(0, 99) < 12) begin
				if ($urandom_range(0, 1)) begin
					send_word(2'($urandom_range(DIR_RAISE, DIR_IDLE)),
						8'($urandom_range(0, 255)), 1'b0);
				end else begin
					send_word(DIR_IDLE, 8'($urandom_range(0, 255)), 1'b1);
				end
			end else begin
				dir  = 2'($urandom_range(DIR_RAISE, DIR_HOLD));
				base = $urandom_range(0, 1) ? $urandom_range(0, cur_band + 4)
					: $urandom_range(0, 255);
				len  = $urandom_range(1, 12);
				repeat (len) begin
					depth = base + int'($urandom_range(0, 4)) - 2;
					if (depth < 0) depth = 0;
					if (depth > 255) depth = 255;
					if ($urandom_range(0, 99) < 20) dir = 2'($urandom_range(DIR_RAISE, DIR_HOLD));
					send_word(dir, depth[7:0], 1'b1);
					done_cnt++;
				end
			end
		end
	endtask

	initial begin
		int ph;
		int kinds[PHASE_COUNT] = '{3, 2, 5, 4, 1, 6, 3, 5, 0, 6};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(DIR_RAISE, 8'd255, 1'b0);
		send_word(DIR_IDLE, 8'd77, 1'b1);
		send_word(DIR_IDLE, 8'd0, 1'b0);
		send_word(DIR_RAISE, 8'd0, 1'b1);
		send_word(DIR_RAISE, 8'd1, 1'b1);
		send_word(DIR_RAISE, 8'd1, 1'b1);
		send_word(DIR_LOWER, 8'd1, 1'b1);
		send_word(DIR_RAISE, 8'd2, 1'b1);
		send_word(DIR_RAISE, 8'd3, 1'b1);
		send_word(DIR_RAISE, 8'd255, 1'b1);
		send_word(DIR_LOWER, 8'd255, 1'b1);
		send_word(DIR_HOLD, 8'd255, 1'b1);
		send_word(DIR_HOLD, 8'd0, 1'b1);
		send_word(DIR_LOWER, 8'd128, 1'b1);
		await_drained();

		// Wide deadband with a large integral gain drives the integral into saturation.
		write_reg(REG_KP_GAIN, 0);
		write_reg(REG_KD_HUNDREDS, 0);
		write_reg(REG_KI_HUNDREDTHS, 255);
		write_reg(REG_CUT_DEADBAND, 255);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		repeat (9) send_word(DIR_RAISE, 8'd254, 1'b1);
		send_word(DIR_LOWER, 8'd254, 1'b1);
		send_word(DIR_HOLD, 8'd255, 1'b1);

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			if (ph == 4) begin
				snd_idle_pct  = 79;
				rcv_stall_pct <= 22;
			end else if (ph == 7) begin
				snd_idle_pct  = 0;
				rcv_stall_pct <= 0;
			end
			await_drained();
			program_settings(kinds[ph]);
			run_phase(PHASE_WORDS);
		end
		await_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d control words, %0d of them engaged, under %0d settings.",
			words_sent, engaged_sent, settings_used);
		$display("Compared %0d result words; %0d mismatches found.",
			results_seen, mismatch_count);
		if (mismatch_count == 0 && words_pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/pvd_pkg.sv
hw/rtl/pvd_regs.sv
hw/rtl/pvd_ctrl.sv
hw/rtl/pvd_datapath.sv
hw/rtl/pid_valve_drive_core.sv
hw/rtl/pvd_checker.sv
sim/pvd_drive_checker.sv
sim/tb_pid_valve_drive_core.sv
